// ===== rtl/rpd_pkg.sv =====
// rpd_pkg: types, codes and helpers shared by the packet deframer files
// no dependencies

package rpd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned ACK_W     = 2;
  localparam int unsigned PKT_LEN_W = 11;

  // framing characters
  localparam logic [BYTE_W-1:0] CH_START = 8'h24;
  localparam logic [BYTE_W-1:0] CH_END   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_RLE   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_EOT   = 8'h04;
  localparam logic [BYTE_W-1:0] ESC_XOR  = 8'h20;

  // event kinds
  localparam logic [KIND_W-1:0] EV_BYTE   = 3'd0;
  localparam logic [KIND_W-1:0] EV_GOOD   = 3'd1;
  localparam logic [KIND_W-1:0] EV_BAD    = 3'd2;
  localparam logic [KIND_W-1:0] EV_ABORT  = 3'd3;
  localparam logic [KIND_W-1:0] EV_CLOSED = 3'd4;

  // acknowledge codes
  localparam logic [ACK_W-1:0] ACK_NONE = 2'd0;
  localparam logic [ACK_W-1:0] ACK_POS  = 2'd1;
  localparam logic [ACK_W-1:0] ACK_NEG  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]    event_kind;
    logic [BYTE_W-1:0]    payload_byte;
    logic [ACK_W-1:0]     ack_to_send;
    logic [PKT_LEN_W-1:0] packet_length;
  } rpd_result_t;

  function automatic logic is_reserved(input logic [BYTE_W-1:0] c);
    return (c == CH_START) || (c == CH_END) || (c == CH_ESC) || (c == CH_RLE);
  endfunction

  // non-hex digits count as zero
  function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end
    return d[3:0];
  endfunction

endpackage

// ===== rtl/rpd_byte_if.sv =====
// rpd_byte_if: valid/ready channel carrying one received serial byte
// depends on rpd_pkg

interface rpd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [rpd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/rpd_event_if.sv =====
// rpd_event_if: valid/ready channel carrying one deframer event
// depends on rpd_pkg

interface rpd_event_if;
  logic                         valid;
  logic                         ready;
  logic [rpd_pkg::KIND_W-1:0]    event_kind;
  logic [rpd_pkg::BYTE_W-1:0]    payload_byte;
  logic [rpd_pkg::ACK_W-1:0]     ack_to_send;
  logic [rpd_pkg::PKT_LEN_W-1:0] packet_length;

  modport source (output valid, output event_kind, output payload_byte,
                  output ack_to_send, output packet_length, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input ack_to_send, input packet_length, output ready);
endinterface

// ===== rtl/rpd_parser.sv =====
// rpd_parser: framing state machine, running checksum and payload count
// depends on rpd_pkg

module rpd_parser #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [rpd_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        noack_mode,
  output logic                        res_valid,
  output rpd_pkg::rpd_result_t        res
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CAPTURE,
    PH_ESCAPE,
    PH_SUM_HI,
    PH_SUM_LO
  } phase_t;

  phase_t                     phase, phase_next;
  logic [rpd_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic [3:0]                 rcv_hi, rcv_hi_next;
  logic [CNT_W-1:0]           payload_count, payload_count_next;

  logic [rpd_pkg::BYTE_W-1:0] resolved;
  logic [rpd_pkg::BYTE_W-1:0] sum_add;
  logic [rpd_pkg::BYTE_W-1:0] sum_take;
  logic [CNT_W-1:0]           count_take;
  logic                       buf_full;

  // payload byte path shared by capture and escape phases
  always_comb begin
    resolved = (phase == PH_ESCAPE) ? (rx_byte ^ rpd_pkg::ESC_XOR) : rx_byte;
    if (rpd_pkg::is_reserved(resolved)) begin
      sum_add = rpd_pkg::CH_ESC + (resolved ^ rpd_pkg::ESC_XOR);
    end else begin
      sum_add = resolved;
    end
    sum_take   = running_sum + sum_add;
    count_take = payload_count + CNT_W'(1);
    buf_full   = (count_take >= CNT_W'(BUFFER_BYTES));
  end

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    rcv_hi_next        = rcv_hi;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res                = '0;
    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == rpd_pkg::CH_START) begin
          phase_next         = PH_CAPTURE;
          payload_count_next = '0;
          running_sum_next   = '0;
        end else if (rx_byte == rpd_pkg::CH_EOT) begin
          res_valid      = 1'b1;
          res.event_kind = rpd_pkg::EV_CLOSED;
        end
      end
      PH_CAPTURE, PH_ESCAPE: begin
        if (phase == PH_CAPTURE && rx_byte == rpd_pkg::CH_START) begin
          // abort and restart at once
          payload_count_next = '0;
          running_sum_next   = '0;
          res_valid          = 1'b1;
          res.event_kind     = rpd_pkg::EV_ABORT;
        end else if (phase == PH_CAPTURE && rx_byte == rpd_pkg::CH_END) begin
          phase_next = PH_SUM_HI;
        end else if (phase == PH_CAPTURE && rx_byte == rpd_pkg::CH_ESC) begin
          phase_next = PH_ESCAPE;
        end else begin
          phase_next         = PH_CAPTURE;
          running_sum_next   = sum_take;
          payload_count_next = count_take;
          res_valid          = 1'b1;
          if (buf_full) begin
            phase_next     = PH_IDLE;
            res.event_kind = rpd_pkg::EV_ABORT;
          end else begin
            res.event_kind   = rpd_pkg::EV_BYTE;
            res.payload_byte = resolved;
          end
        end
      end
      PH_SUM_HI: begin
        if (!noack_mode) begin
          rcv_hi_next = rpd_pkg::hex_value(rx_byte);
        end
        phase_next = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        if (noack_mode) begin
          res.event_kind    = rpd_pkg::EV_GOOD;
          res.packet_length = rpd_pkg::PKT_LEN_W'(payload_count);
        end else if ({rcv_hi, rpd_pkg::hex_value(rx_byte)} == running_sum) begin
          res.event_kind    = rpd_pkg::EV_GOOD;
          res.ack_to_send   = rpd_pkg::ACK_POS;
          res.packet_length = rpd_pkg::PKT_LEN_W'(payload_count);
        end else begin
          res.event_kind  = rpd_pkg::EV_BAD;
          res.ack_to_send = rpd_pkg::ACK_NEG;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      running_sum   <= '0;
      rcv_hi        <= '0;
      payload_count <= '0;
    end else if (step) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      rcv_hi        <= rcv_hi_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

// ===== rtl/rsp_packet_deframer.sv =====
// an accepted byte waits in the input register; its event goes to the event register
// throughput: one byte per cycle unless a held event stalls the parse step
// framing state and checksum update in the parse step, also for a byte with no event
// reset (rst, synchronous) empties both registers, returns to idle and clears noack_mode
// rsp_packet_deframer: input register, parser and event register
// depends on rpd_pkg, rpd_byte_if, rpd_event_if, rpd_parser

module rsp_packet_deframer #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  rpd_byte_if.sink     rx,
  rpd_event_if.source  evt
);

  logic                       noack_mode;
  logic                       in_valid;
  logic [rpd_pkg::BYTE_W-1:0] in_byte;
  logic                       out_valid;
  rpd_pkg::rpd_result_t       out_res;

  logic                       res_valid;
  rpd_pkg::rpd_result_t       res;
  logic                       step;

  // a word with no event never waits on the output side
  assign step     = in_valid && (!out_valid || evt.ready || !res_valid);
  assign rx.ready = !in_valid || step;

  rpd_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (in_byte),
    .noack_mode (noack_mode),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      noack_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      noack_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign evt.valid         = out_valid;
  assign evt.event_kind    = out_res.event_kind;
  assign evt.payload_byte  = out_res.payload_byte;
  assign evt.ack_to_send   = out_res.ack_to_send;
  assign evt.packet_length = out_res.packet_length;

endmodule

// ===== rtl/rpd_checker.sv =====
// rpd_checker: port-level checks on the deframer event stream, bound to the top
// depends on rpd_pkg, rsp_packet_deframer

module rpd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          evt_valid,
  input logic                          evt_ready,
  input logic [rpd_pkg::KIND_W-1:0]    event_kind,
  input logic [rpd_pkg::BYTE_W-1:0]    payload_byte,
  input logic [rpd_pkg::ACK_W-1:0]     ack_to_send,
  input logic [rpd_pkg::PKT_LEN_W-1:0] packet_length
);

  // a stalled word keeps its contents
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(event_kind)
      && $stable(payload_byte) && $stable(ack_to_send) && $stable(packet_length))
    else $error("event word changed while stalled");

  // '+' goes only with a good packet, '-' only with a bad checksum
  a_ack_kind: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> (ack_to_send == rpd_pkg::ACK_NONE)
      || (ack_to_send == rpd_pkg::ACK_POS && event_kind == rpd_pkg::EV_GOOD)
      || (ack_to_send == rpd_pkg::ACK_NEG && event_kind == rpd_pkg::EV_BAD))
    else $error("acknowledge does not match event kind");

  // payload data and length are zero outside their own event kinds
  a_fields_clear: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> (event_kind == rpd_pkg::EV_BYTE || payload_byte == '0)
      && (event_kind == rpd_pkg::EV_GOOD || packet_length == '0))
    else $error("event carries stray payload or length");

  // a bad checksum always asks for a resend
  a_bad_nack: assert property (@(posedge clk) disable iff (rst)
    evt_valid && event_kind == rpd_pkg::EV_BAD |-> ack_to_send == rpd_pkg::ACK_NEG)
    else $error("bad checksum without nack");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("event offered after reset");

endmodule

bind rsp_packet_deframer rpd_checker u_rpd_checker (
  .clk           (clk),
  .rst           (rst),
  .evt_valid     (evt.valid),
  .evt_ready     (evt.ready),
  .event_kind    (evt.event_kind),
  .payload_byte  (evt.payload_byte),
  .ack_to_send   (evt.ack_to_send),
  .packet_length (evt.packet_length)
);
